[rtl/core/srrip_pkg.sv]
package srrip_pkg;

    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_FILL   = 3'd1;
    localparam logic [2:0] CMD_HIT    = 3'd2;
    localparam logic [2:0] CMD_INVAL  = 3'd3;
    localparam logic [2:0] CMD_VICTIM = 3'd4;

    localparam logic [2:0] EVICT_LVL_RESET = 3'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] tag;
        logic [3:0]  way;
        logic        promote;
        logic        pin_write;
        logic [15:0] busy_mask;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [3:0] way_out;
    } rsp_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_LOOKUP,
        RES_VICTIM
    } res_src_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     apply;
        logic     age;
        logic     res_load;
        res_src_t res_src;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] command;
        logic       free_hit;
        logic       any_at;
    } dp_stat_t;

endpackage

[rtl/core/srrip_if.sv]
interface srrip_req_if;
    logic            valid;
    logic            ready;
    srrip_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface srrip_rsp_if;
    logic            valid;
    logic            ready;
    srrip_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface srrip_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/srrip_ctrl.sv]
module srrip_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  srrip_pkg::dp_stat_t stat,
    output srrip_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEL
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    // result slot can take a word this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load     = 1'b0;
        cmd.apply    = 1'b0;
        cmd.age      = 1'b0;
        cmd.res_load = 1'b0;
        cmd.res_src  = srrip_pkg::RES_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_EVAL:
            begin
                if (stat.command == srrip_pkg::CMD_VICTIM && !stat.free_hit && !stat.any_at)
                begin
                    cmd.age = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.apply    = 1'b1;
                    cmd.res_load = 1'b1;
                    case (stat.command)
                        srrip_pkg::CMD_LOOKUP: cmd.res_src = srrip_pkg::RES_LOOKUP;
                        srrip_pkg::CMD_VICTIM: cmd.res_src = srrip_pkg::RES_VICTIM;
                        default:               cmd.res_src = srrip_pkg::RES_NONE;
                    endcase
                end
            end
            ST_SEL:
            begin
                if (out_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = srrip_pkg::RES_VICTIM;
                end
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (cmd.age)
                    begin
                        state_reg <= ST_SEL;
                    end
                    else if (cmd.res_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SEL:
                begin
                    if (cmd.res_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/srrip_dp.sv]
module srrip_dp
#(
    parameter int WAYS     = 16,
    parameter int TAG_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  srrip_pkg::req_t     req_in,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_data,
    input  srrip_pkg::dp_cmd_t  cmd,
    output srrip_pkg::dp_stat_t stat,
    output srrip_pkg::rsp_t     rsp_out
);

    localparam int WB = $clog2(WAYS);
    localparam int TW = (TAG_BITS < 32) ? TAG_BITS : 32;

    srrip_pkg::req_t req_reg;
    logic [2:0]      evict_lvl_reg;
    logic [TW-1:0]   tag_reg [WAYS];
    logic [WAYS-1:0] valid_reg;
    logic [WAYS-1:0] pinned_reg;
    logic [2:0]      rrpv_reg [WAYS];
    logic            found_reg;
    logic [3:0]      way_out_reg;

    logic [TW-1:0]   tag_in;
    logic [WB-1:0]   widx;
    logic            in_range;
    logic [WAYS-1:0] at_lvl;
    logic [7:0]      present;
    logic [2:0]      top_rrpv;
    logic [2:0]      gap;
    logic            look_hit;
    logic [WB-1:0]   look_way;
    logic            free_hit;
    logic [WB-1:0]   free_way;
    logic            unpin_hit;
    logic [WB-1:0]   unpin_way;
    logic            pin_hit;
    logic [WB-1:0]   pin_way;
    logic            vict_hit;
    logic [WB-1:0]   vict_way;

    assign tag_in   = req_reg.tag[TW-1:0];
    assign widx     = req_reg.way[WB-1:0];
    assign in_range = ({1'b0, req_reg.way} < 5'(WAYS));

    always_comb
    begin
        present = 8'd0;
        for (int i = 0; i < WAYS; i++)
        begin
            at_lvl[i] = (rrpv_reg[i] >= evict_lvl_reg);
            present   = present | (8'd1 << rrpv_reg[i]);
        end
        top_rrpv = 3'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (present[k])
            begin
                top_rrpv = 3'(k);
            end
        end
    end

    // only used when every way sits below the level, so the top is below too
    assign gap = evict_lvl_reg - top_rrpv;

    // descending scans: the lowest qualifying way wins
    always_comb
    begin
        look_hit  = 1'b0;
        look_way  = '0;
        free_hit  = 1'b0;
        free_way  = '0;
        unpin_hit = 1'b0;
        unpin_way = '0;
        pin_hit   = 1'b0;
        pin_way   = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == tag_in)
            begin
                look_hit = 1'b1;
                look_way = WB'(i);
            end
            if (!valid_reg[i])
            begin
                free_hit = 1'b1;
                free_way = WB'(i);
            end
            if (at_lvl[i] && !pinned_reg[i] && !req_reg.busy_mask[i])
            begin
                unpin_hit = 1'b1;
                unpin_way = WB'(i);
            end
            if (at_lvl[i] && pinned_reg[i])
            begin
                pin_hit = 1'b1;
                pin_way = WB'(i);
            end
        end
    end

    always_comb
    begin
        vict_hit = 1'b1;
        if (free_hit)
        begin
            vict_way = free_way;
        end
        else if (unpin_hit)
        begin
            vict_way = unpin_way;
        end
        else if (pin_hit)
        begin
            vict_way = pin_way;
        end
        else
        begin
            vict_hit = 1'b0;
            vict_way = '0;
        end
    end

    assign stat.command  = req_reg.command;
    assign stat.free_hit = free_hit;
    assign stat.any_at   = |at_lvl;

    assign rsp_out.found   = found_reg;
    assign rsp_out.way_out = way_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_in;
        end
        if (cmd.res_load)
        begin
            case (cmd.res_src)
                srrip_pkg::RES_LOOKUP:
                begin
                    found_reg   <= look_hit;
                    way_out_reg <= look_hit ? 4'(look_way) : 4'd0;
                end
                srrip_pkg::RES_VICTIM:
                begin
                    found_reg   <= vict_hit;
                    way_out_reg <= 4'(vict_way);
                end
                default:
                begin
                    found_reg   <= 1'b0;
                    way_out_reg <= 4'd0;
                end
            endcase
        end
        if (cmd.apply && req_reg.command == srrip_pkg::CMD_FILL && in_range)
        begin
            tag_reg[widx] <= tag_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evict_lvl_reg <= srrip_pkg::EVICT_LVL_RESET;
            valid_reg     <= '0;
            pinned_reg    <= '0;
            for (int i = 0; i < WAYS; i++)
            begin
                rrpv_reg[i] <= 3'd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                evict_lvl_reg <= cfg_data;
            end
            if (cmd.apply && in_range)
            begin
                case (req_reg.command)
                    srrip_pkg::CMD_FILL:
                    begin
                        valid_reg[widx]  <= 1'b1;
                        pinned_reg[widx] <= 1'b0;
                        rrpv_reg[widx]   <= 3'd0;
                    end
                    srrip_pkg::CMD_HIT:
                    begin
                        if (valid_reg[widx])
                        begin
                            if (req_reg.pin_write && !pinned_reg[widx])
                            begin
                                pinned_reg[widx] <= 1'b1;
                            end
                            if ((req_reg.pin_write && !pinned_reg[widx]) || req_reg.promote)
                            begin
                                rrpv_reg[widx] <= 3'd0;
                            end
                        end
                    end
                    srrip_pkg::CMD_INVAL:
                    begin
                        valid_reg[widx]  <= 1'b0;
                        pinned_reg[widx] <= 1'b0;
                        rrpv_reg[widx]   <= 3'd0;
                    end
                    default:
                    begin
                        valid_reg <= valid_reg;
                    end
                endcase
            end
            if (cmd.age)
            begin
                for (int i = 0; i < WAYS; i++)
                begin
                    if (!at_lvl[i])
                    begin
                        rrpv_reg[i] <= rrpv_reg[i] + gap;
                    end
                end
            end
        end
    end

endmodule

[rtl/core/srrip_set_replacement_core.sv]
// One cache set under static RRIP replacement.
// req channel: one word per command (lookup, fill, hit update, invalidate,
// choose victim) with tag, way, promote, pin_write and busy_mask.
// rsp channel: exactly one word per request, found and way_out; found is 0
// for commands other than lookup and victim.
// cfg channel: writes the eviction level, always ready; write only while idle.
// A request accepted in the idle state is evaluated in the EVAL state, and
// its response is registered as the sequencer leaves EVAL for idle.
// A victim request that has to age the set also passes through the SEL state:
// the EVAL state writes the aged RRPVs, and SEL picks the way from them.
// One request is in flight at a time; req ready is high while the sequencer
// waits for work, also while an earlier response still sits unclaimed.
// If rsp is stalled, evaluation holds until the response register frees, and
// no state update is made until then, except the ageing step of a victim
// request, which goes ahead before the wait.
// Reset: all ways invalid, unpinned, RRPV 0, eviction level 3; tags are not
// cleared, only valid ways are compared.
module srrip_set_replacement_core
#(
    parameter int WAYS     = 16,
    parameter int TAG_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    srrip_req_if.sink   req,
    srrip_rsp_if.source rsp,
    srrip_cfg_if.sink   cfg
);

    srrip_pkg::dp_cmd_t  dp_cmd;
    srrip_pkg::dp_stat_t dp_stat;
    logic                cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    srrip_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    srrip_dp
    #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_in   (req.payload),
        .cfg_we   (cfg_we),
        .cfg_data (cfg.payload),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .rsp_out  (rsp.payload)
    );

endmodule
